[rtl/dibs_pkg.sv]
// ----------------------------------------------------------------------------
// dibs_pkg
// Shared types and constants of the deformable bilinear sampler.
// ----------------------------------------------------------------------------
package dibs_pkg;

    localparam int CHANNELS   = 4;
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_WIDTH  = 64;
    localparam int FRAC_BITS  = 8;

    localparam int CH_W    = 2;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int KER_W   = 4;
    localparam int OFF_W   = 15;
    localparam int PIX_W   = 16;
    localparam int SIZE_W  = 7;
    localparam int WGT_W   = FRAC_BITS + 1;
    localparam int ADDR_W  = CH_W + ROW_W + COL_W;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [WGT_W-1:0]  ONE_FIX  = WGT_W'(1 << FRAC_BITS);
    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] H_MAX    = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] W_MAX    = SIZE_W'(MAX_WIDTH);

    localparam logic REG_HEIGHT = 1'b0;
    localparam logic REG_WIDTH  = 1'b1;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic                     is_sample;
        logic [CH_W-1:0]          channel;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic signed [PIX_W-1:0]  pixel;
        logic [WGT_W-1:0]         w_top;
        logic [WGT_W-1:0]         w_left;
        logic [WGT_W-1:0]         w_bottom;
        logic [WGT_W-1:0]         w_right;
    } t_cmd;

    typedef struct packed {
        logic signed [PIX_W-1:0]  sample_value;
        logic [CH_W-1:0]          channel;
        logic [ROW_W-1:0]         corner_row;
        logic [COL_W-1:0]         corner_col;
        logic [WGT_W-1:0]         w_top;
        logic [WGT_W-1:0]         w_left;
        logic [WGT_W-1:0]         w_bottom;
        logic [WGT_W-1:0]         w_right;
    } t_result;

endpackage

[rtl/dibs_front.sv]
// ----------------------------------------------------------------------------
// dibs_front
// Accepts input beats, works out the clamped corner and the four weights of a
// sample, and holds the commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module dibs_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [dibs_pkg::SIZE_W-1:0]         i_height,
    input  logic [dibs_pkg::SIZE_W-1:0]         i_width,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic                                i_action,
    input  logic [dibs_pkg::CH_W-1:0]           i_channel,
    input  logic [dibs_pkg::ROW_W-1:0]          i_row,
    input  logic [dibs_pkg::COL_W-1:0]          i_col,
    input  logic [dibs_pkg::KER_W-1:0]          i_kernel_row,
    input  logic [dibs_pkg::KER_W-1:0]          i_kernel_col,
    input  logic signed [dibs_pkg::OFF_W-1:0]   i_y_offset,
    input  logic signed [dibs_pkg::OFF_W-1:0]   i_x_offset,
    input  logic signed [dibs_pkg::PIX_W-1:0]   i_pixel_value,
    output logic                                o_cmd_valid,
    output dibs_pkg::t_cmd                      o_cmd,
    input  logic                                i_cmd_pop
);
    import dibs_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [ROW_W-1:0] corner;
        logic [WGT_W-1:0] frac;
    } t_axis;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_MIN) begin
            r = SIZE_MIN;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic t_axis locate(input logic [ROW_W-1:0] base,
                                     input logic [KER_W-1:0] kern,
                                     input logic signed [OFF_W-1:0] off,
                                     input logic [SIZE_W-1:0] n);
        logic [ROW_W:0]                  tap;
        logic signed [ROW_W+FRAC_BITS+2:0] pos;
        logic [ROW_W+FRAC_BITS-1:0]      top;
        logic [ROW_W+FRAC_BITS-1:0]      c;
        t_axis                           r;
        tap = {1'b0, base} + (ROW_W+1)'(kern);
        pos = $signed({2'b00, tap, FRAC_BITS'(0)}) + (ROW_W+FRAC_BITS+3)'(off);
        top = {ROW_W'(n - SIZE_W'(1)), FRAC_BITS'(0)};
        if (pos < 0) begin
            c = '0;
        end else if (pos > $signed({3'b000, top})) begin
            c = top;
        end else begin
            c = pos[ROW_W+FRAC_BITS-1:0];
        end
        if ({1'b0, c[ROW_W+FRAC_BITS-1:FRAC_BITS]} >= (n - SIZE_W'(1))) begin
            r.corner = ROW_W'(n - SIZE_W'(2));
            r.frac   = ONE_FIX;
        end else begin
            r.corner = c[ROW_W+FRAC_BITS-1:FRAC_BITS];
            r.frac   = {1'b0, c[FRAC_BITS-1:0]};
        end
        return r;
    endfunction

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    t_axis ay;
    t_axis ax;
    t_cmd  cmd_in;
    logic  push_acc;
    logic  pop_acc;

    always_comb begin
        ay = locate(i_row, i_kernel_row, i_y_offset, clamp_size(i_height, H_MAX));
        ax = locate(i_col, i_kernel_col, i_x_offset, clamp_size(i_width, W_MAX));
        cmd_in.is_sample = (i_action == ACT_SAMPLE);
        cmd_in.channel   = i_channel;
        cmd_in.pixel     = i_pixel_value;
        cmd_in.w_top     = ONE_FIX - ay.frac;
        cmd_in.w_bottom  = ay.frac;
        cmd_in.w_left    = ONE_FIX - ax.frac;
        cmd_in.w_right   = ax.frac;
        if (i_action == ACT_SAMPLE) begin
            cmd_in.row = ay.corner;
            cmd_in.col = ax.corner;
        end else begin
            cmd_in.row = i_row;
            cmd_in.col = i_col;
        end
    end

    assign o_full      = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd];
    assign push_acc    = i_push && !o_full;
    assign pop_acc     = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (push_acc) begin
            r_q[r_wr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_acc) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop_acc) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_count <= r_count + (QPTR_W+1)'(push_acc) - (QPTR_W+1)'(pop_acc);
        end
    end

endmodule

[rtl/dibs_back.sv]
// ----------------------------------------------------------------------------
// dibs_back
// Holds the image memory, writes loads, reads the four neighbours of a sample
// one per cycle, multiplies and accumulates them, and queues the results.
// ----------------------------------------------------------------------------
module dibs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  dibs_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output dibs_pkg::t_result o_result
);
    import dibs_pkg::*;

    localparam int DEPTH   = CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int ODEPTH  = 4;
    localparam int OPTR_W  = $clog2(ODEPTH);
    localparam int PROD_W  = 2 * FRAC_BITS + 1;
    localparam int MUL_W   = PIX_W + PROD_W + 1;
    localparam int ACC_W   = MUL_W;
    localparam int Q_W     = ACC_W - 2 * FRAC_BITS;

    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((1 << (PIX_W - 1)) - 1);
    localparam logic signed [Q_W-1:0] SAT_LO = -Q_W'(1 << (PIX_W - 1));

    logic signed [PIX_W-1:0] r_mem [DEPTH];
    logic signed [PIX_W-1:0] r_rdata;

    logic             r_busy;
    logic [1:0]       r_k;
    t_cmd             r_cur;
    logic [OPTR_W:0]  r_credit;

    logic              r_s1_valid;
    logic              r_s1_first;
    logic              r_s1_last;
    logic [PROD_W-1:0] r_s1_wprod;
    t_cmd              r_s1_cmd;

    logic                     r_s2_valid;
    logic                     r_s2_first;
    logic                     r_s2_last;
    logic signed [MUL_W-1:0]  r_s2_prod;
    t_cmd                     r_s2_cmd;

    logic signed [ACC_W-1:0]  r_acc;

    t_result           r_oq [ODEPTH];
    logic [OPTR_W-1:0] r_owr;
    logic [OPTR_W-1:0] r_ord;
    logic [OPTR_W:0]   r_ocount;

    logic                    start_sample;
    logic                    do_load;
    logic                    issue;
    logic [1:0]              k;
    t_cmd                    cur;
    logic [ADDR_W-1:0]       addr;
    logic [WGT_W-1:0]        wy;
    logic [WGT_W-1:0]        wx;
    logic [2*WGT_W-1:0]      wprod;
    logic signed [MUL_W-1:0] prod;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [Q_W-1:0]   q;
    t_result                 res;
    logic                    res_push;
    logic                    pop_acc;

    assign start_sample = !r_busy && i_cmd_valid && i_cmd.is_sample
                          && (r_credit != (OPTR_W+1)'(ODEPTH));
    assign do_load      = !r_busy && i_cmd_valid && !i_cmd.is_sample;
    assign o_cmd_pop    = start_sample || do_load;
    assign issue        = start_sample || r_busy;
    assign k            = r_busy ? r_k : 2'd0;
    assign cur          = r_busy ? r_cur : i_cmd;
    assign addr         = {cur.channel, cur.row + ROW_W'(k[1]), cur.col + COL_W'(k[0])};
    assign wy           = k[1] ? cur.w_bottom : cur.w_top;
    assign wx           = k[0] ? cur.w_right : cur.w_left;
    assign wprod        = wy * wx;

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_mem[addr] <= cur.pixel;
        end else begin
            r_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 2'd0;
        end else if (start_sample) begin
            r_busy <= 1'b1;
            r_k    <= 2'd1;
        end else if (r_busy) begin
            r_k <= r_k + 2'd1;
            if (r_k == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_sample) begin
            r_cur <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
        end
    end

    assign prod = $signed(r_rdata) * $signed({1'b0, r_s1_wprod});

    always_ff @(posedge i_clk) begin
        r_s1_first <= (k == 2'd0);
        r_s1_last  <= (k == 2'd3);
        r_s1_wprod <= wprod[PROD_W-1:0];
        r_s1_cmd   <= cur;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_prod  <= prod;
        r_s2_cmd   <= r_s1_cmd;
    end

    always_comb begin
        acc_next = (r_s2_first ? ACC_W'(0) : r_acc) + r_s2_prod;
        q        = acc_next[ACC_W-1:2*FRAC_BITS];
        if (q > SAT_HI) begin
            res.sample_value = SAT_HI[PIX_W-1:0];
        end else if (q < SAT_LO) begin
            res.sample_value = SAT_LO[PIX_W-1:0];
        end else begin
            res.sample_value = q[PIX_W-1:0];
        end
        res.channel    = r_s2_cmd.channel;
        res.corner_row = r_s2_cmd.row;
        res.corner_col = r_s2_cmd.col;
        res.w_top      = r_s2_cmd.w_top;
        res.w_left     = r_s2_cmd.w_left;
        res.w_bottom   = r_s2_cmd.w_bottom;
        res.w_right    = r_s2_cmd.w_right;
    end

    assign res_push = r_s2_valid && r_s2_last;

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_acc <= acc_next;
        end
    end

    assign o_empty  = (r_ocount == '0);
    assign o_result = r_oq[r_ord];
    assign pop_acc  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_oq[r_owr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr    <= '0;
            r_ord    <= '0;
            r_ocount <= '0;
            r_credit <= '0;
        end else begin
            if (res_push) begin
                r_owr <= r_owr + OPTR_W'(1);
            end
            if (pop_acc) begin
                r_ord <= r_ord + OPTR_W'(1);
            end
            r_ocount <= r_ocount + (OPTR_W+1)'(res_push) - (OPTR_W+1)'(pop_acc);
            r_credit <= r_credit + (OPTR_W+1)'(start_sample) - (OPTR_W+1)'(pop_acc);
        end
    end

endmodule

[rtl/deformable_im2col_bilinear_sampler_top.sv]
// ----------------------------------------------------------------------------
// deformable_im2col_bilinear_sampler_top
// Deformable convolution bilinear sampler over a four-channel image of up to 64x64 pixels.
// ----------------------------------------------------------------------------
// A load beat writes one pixel into the image memory. A sample beat reads its
// four neighbours one at a time from the single-port image memory, so the
// back end takes no new beat until the last read of a sample is issued; loads
// run at one per cycle while the back end is not busy with a sample. The image
// memory is not cleared after reset, so every pixel a sample touches must have
// been loaded first. The height and width registers (byte addresses 0 and 4)
// may be written only while the block is idle.
module deformable_im2col_bilinear_sampler_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dibs_pkg::APB_AW-1:0]         paddr,
    input  logic [dibs_pkg::APB_DW-1:0]         pwdata,
    output logic [dibs_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_action,
    input  logic [dibs_pkg::CH_W-1:0]           i_channel,
    input  logic [dibs_pkg::ROW_W-1:0]          i_row,
    input  logic [dibs_pkg::COL_W-1:0]          i_col,
    input  logic [dibs_pkg::KER_W-1:0]          i_kernel_row,
    input  logic [dibs_pkg::KER_W-1:0]          i_kernel_col,
    input  logic signed [dibs_pkg::OFF_W-1:0]   i_y_offset,
    input  logic signed [dibs_pkg::OFF_W-1:0]   i_x_offset,
    input  logic signed [dibs_pkg::PIX_W-1:0]   i_pixel_value,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [dibs_pkg::PIX_W-1:0]   o_sample_value,
    output logic [dibs_pkg::CH_W-1:0]           o_sampled_channel,
    output logic [dibs_pkg::ROW_W-1:0]          o_corner_row,
    output logic [dibs_pkg::COL_W-1:0]          o_corner_col,
    output logic [dibs_pkg::WGT_W-1:0]          o_weight_top,
    output logic [dibs_pkg::WGT_W-1:0]          o_weight_left,
    output logic [dibs_pkg::WGT_W-1:0]          o_weight_bottom,
    output logic [dibs_pkg::WGT_W-1:0]          o_weight_right
);
    import dibs_pkg::*;

    logic [SIZE_W-1:0] r_height;
    logic [SIZE_W-1:0] r_width;
    logic              cfg_wr;
    logic              cmd_valid;
    logic              cmd_pop;
    t_cmd              cmd;
    t_result           result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_WIDTH) ? APB_DW'(r_width) : APB_DW'(r_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= H_MAX;
            r_width  <= W_MAX;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HEIGHT) begin
                r_height <= pwdata[SIZE_W-1:0];
            end else begin
                r_width <= pwdata[SIZE_W-1:0];
            end
        end
    end

    dibs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_height      (r_height),
        .i_width       (r_width),
        .i_push        (push),
        .o_full        (full),
        .i_action      (i_action),
        .i_channel     (i_channel),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_kernel_row  (i_kernel_row),
        .i_kernel_col  (i_kernel_col),
        .i_y_offset    (i_y_offset),
        .i_x_offset    (i_x_offset),
        .i_pixel_value (i_pixel_value),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    dibs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (result)
    );

    assign o_sample_value    = result.sample_value;
    assign o_sampled_channel = result.channel;
    assign o_corner_row      = result.corner_row;
    assign o_corner_col      = result.corner_col;
    assign o_weight_top      = result.w_top;
    assign o_weight_left     = result.w_left;
    assign o_weight_bottom   = result.w_bottom;
    assign o_weight_right    = result.w_right;

endmodule

[tb/sv/dibs_sample_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dibs_sample_checker
// Watches the configuration port and both beat channels of the deformable
// bilinear sampler. It keeps its own pixel memory and size registers, works
// out the expected result of every accepted sample beat, and compares each
// accepted result beat field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module dibs_sample_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [dibs_pkg::APB_AW-1:0]         i_paddr,
    input  logic [dibs_pkg::APB_DW-1:0]         i_pwdata,
    input  logic                                i_push,
    input  logic                                i_full,
    input  logic                                i_action,
    input  logic [dibs_pkg::CH_W-1:0]           i_channel,
    input  logic [dibs_pkg::ROW_W-1:0]          i_row,
    input  logic [dibs_pkg::COL_W-1:0]          i_col,
    input  logic [dibs_pkg::KER_W-1:0]          i_kernel_row,
    input  logic [dibs_pkg::KER_W-1:0]          i_kernel_col,
    input  logic signed [dibs_pkg::OFF_W-1:0]   i_y_offset,
    input  logic signed [dibs_pkg::OFF_W-1:0]   i_x_offset,
    input  logic signed [dibs_pkg::PIX_W-1:0]   i_pixel_value,
    input  logic                                i_empty,
    input  logic                                i_pop,
    input  logic signed [dibs_pkg::PIX_W-1:0]   i_sample_value,
    input  logic [dibs_pkg::CH_W-1:0]           i_sampled_channel,
    input  logic [dibs_pkg::ROW_W-1:0]          i_corner_row,
    input  logic [dibs_pkg::COL_W-1:0]          i_corner_col,
    input  logic [dibs_pkg::WGT_W-1:0]          i_weight_top,
    input  logic [dibs_pkg::WGT_W-1:0]          i_weight_left,
    input  logic [dibs_pkg::WGT_W-1:0]          i_weight_bottom,
    input  logic [dibs_pkg::WGT_W-1:0]          i_weight_right,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_loads,
    output int                                  o_samples
);
    import dibs_pkg::*;

    logic signed [PIX_W-1:0] pixel_mem [1 << ADDR_W];
    logic [SIZE_W-1:0]       height_reg;
    logic [SIZE_W-1:0]       width_reg;
    t_result                 awaited_samples [$];
    int                      mismatches;
    int                      load_count;
    int                      sample_count;

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_loads = 0;
        o_samples = 0;
        mismatches = 0;
        load_count = 0;
        sample_count = 0;
        height_reg = H_MAX;
        width_reg = W_MAX;
    end

    function automatic int used_size(input logic [SIZE_W-1:0] v, input int hi);
        if (v < SIZE_MIN) return int'(SIZE_MIN);
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    function automatic void clamp_axis(input int pos, input int n,
                                       output int corner, output int frac);
        int last_pos;
        last_pos = (n - 1) << FRAC_BITS;
        if (pos < 0) pos = 0;
        if (pos > last_pos) pos = last_pos;
        corner = pos >> FRAC_BITS;
        if (corner >= n - 1) corner = n - 2;
        frac = pos - (corner << FRAC_BITS);
    endfunction

    function automatic longint stored_pixel(input logic [CH_W-1:0] ch, input int r,
                                            input int c);
        return longint'(pixel_mem[{ch, ROW_W'(r), COL_W'(c)}]);
    endfunction

    function automatic t_result bilinear_sample(
        input logic [CH_W-1:0]         ch,
        input logic [ROW_W-1:0]        row,
        input logic [COL_W-1:0]        col,
        input logic [KER_W-1:0]        kr,
        input logic [KER_W-1:0]        kc,
        input logic signed [OFF_W-1:0] yo,
        input logic signed [OFF_W-1:0] xo
    );
        t_result r;
        int      one;
        int      ay, ax, fy, fx;
        longint  wt, wl, wb, wr, acc, q;
        one = 1 << FRAC_BITS;
        clamp_axis((int'(row) + int'(kr)) * one + int'(yo),
                   used_size(height_reg, MAX_HEIGHT), ay, fy);
        clamp_axis((int'(col) + int'(kc)) * one + int'(xo),
                   used_size(width_reg, MAX_WIDTH), ax, fx);
        wt = one - fy;
        wb = fy;
        wl = one - fx;
        wr = fx;
        acc = wt * wl * stored_pixel(ch, ay, ax)
            + wt * wr * stored_pixel(ch, ay, ax + 1)
            + wb * wl * stored_pixel(ch, ay + 1, ax)
            + wb * wr * stored_pixel(ch, ay + 1, ax + 1);
        q = acc >>> (2 * FRAC_BITS);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        r.sample_value = PIX_W'(q);
        r.channel = ch;
        r.corner_row = ROW_W'(ay);
        r.corner_col = COL_W'(ax);
        r.w_top = WGT_W'(wt);
        r.w_left = WGT_W'(wl);
        r.w_bottom = WGT_W'(wb);
        r.w_right = WGT_W'(wr);
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            height_reg = H_MAX;
            width_reg = W_MAX;
            awaited_samples.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[APB_AW-1:2] == REG_HEIGHT) begin
                    height_reg = i_pwdata[SIZE_W-1:0];
                end else begin
                    width_reg = i_pwdata[SIZE_W-1:0];
                end
            end
            if (i_pop && !i_empty) begin
                if (awaited_samples.size() == 0) begin
                    $display("%0t ns: result beat with no sample outstanding, got value %0d",
                             $time, i_sample_value);
                    mismatches++;
                end else begin
                    want = awaited_samples.pop_front();
                    compare_field("sample_value", int'(want.sample_value),
                                  int'(i_sample_value));
                    compare_field("sampled_channel", want.channel, i_sampled_channel);
                    compare_field("corner_row", want.corner_row, i_corner_row);
                    compare_field("corner_col", want.corner_col, i_corner_col);
                    compare_field("weight_top", want.w_top, i_weight_top);
                    compare_field("weight_left", want.w_left, i_weight_left);
                    compare_field("weight_bottom", want.w_bottom, i_weight_bottom);
                    compare_field("weight_right", want.w_right, i_weight_right);
                end
            end
            if (i_push && !i_full) begin
                if (i_action == ACT_LOAD) begin
                    pixel_mem[{i_channel, i_row, i_col}] = i_pixel_value;
                    load_count++;
                end else begin
                    awaited_samples.push_back(bilinear_sample(i_channel, i_row, i_col,
                        i_kernel_row, i_kernel_col, i_y_offset, i_x_offset));
                    sample_count++;
                end
            end
        end
        o_pending <= awaited_samples.size();
        o_errors <= mismatches;
        o_loads <= load_count;
        o_samples <= sample_count;
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the deformable bilinear sampler.
// Sets the image size over several settings, loads pixels and sends sample
// beats with random idling on both sides, one long result hold-off, and
// leaves all prediction and comparison to the sample checker.
// ----------------------------------------------------------------------------
module tb;
    import dibs_pkg::*;

    localparam int PHASES          = 10;
    localparam int BEATS_PER_PHASE = 105;
    localparam int LONG_HOLD_AT    = 150;
    localparam int LONG_HOLD       = 400;
    localparam int QUIET_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 20;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_AW-1:0]       paddr;
    logic [APB_DW-1:0]       pwdata;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;
    logic                    push;
    logic                    full;
    logic                    i_action;
    logic [CH_W-1:0]         i_channel;
    logic [ROW_W-1:0]        i_row;
    logic [COL_W-1:0]        i_col;
    logic [KER_W-1:0]        i_kernel_row;
    logic [KER_W-1:0]        i_kernel_col;
    logic signed [OFF_W-1:0] i_y_offset;
    logic signed [OFF_W-1:0] i_x_offset;
    logic signed [PIX_W-1:0] i_pixel_value;
    logic                    empty;
    logic                    pop;
    logic signed [PIX_W-1:0] o_sample_value;
    logic [CH_W-1:0]         o_sampled_channel;
    logic [ROW_W-1:0]        o_corner_row;
    logic [COL_W-1:0]        o_corner_col;
    logic [WGT_W-1:0]        o_weight_top;
    logic [WGT_W-1:0]        o_weight_left;
    logic [WGT_W-1:0]        o_weight_bottom;
    logic [WGT_W-1:0]        o_weight_right;

    int errors;
    int pending;
    int loads_seen;
    int samples_seen;
    int stalled_cycles;
    int beats_sent;
    int burst_left;
    int rows_used;
    int cols_used;
    bit loaded [1 << ADDR_W];

    logic [SIZE_W-1:0] phase_h [8] = '{7'd64, 7'd2, 7'd2,  7'd64, 7'd0, 7'd127, 7'd5, 7'd1};
    logic [SIZE_W-1:0] phase_w [8] = '{7'd64, 7'd2, 7'd64, 7'd2,  7'd1, 7'd100, 7'd9, 7'd65};

    deformable_im2col_bilinear_sampler_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .push              (push),
        .full              (full),
        .i_action          (i_action),
        .i_channel         (i_channel),
        .i_row             (i_row),
        .i_col             (i_col),
        .i_kernel_row      (i_kernel_row),
        .i_kernel_col      (i_kernel_col),
        .i_y_offset        (i_y_offset),
        .i_x_offset        (i_x_offset),
        .i_pixel_value     (i_pixel_value),
        .empty             (empty),
        .pop               (pop),
        .o_sample_value    (o_sample_value),
        .o_sampled_channel (o_sampled_channel),
        .o_corner_row      (o_corner_row),
        .o_corner_col      (o_corner_col),
        .o_weight_top      (o_weight_top),
        .o_weight_left     (o_weight_left),
        .o_weight_bottom   (o_weight_bottom),
        .o_weight_right    (o_weight_right)
    );

    dibs_sample_checker chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_push            (push),
        .i_full            (full),
        .i_action          (i_action),
        .i_channel         (i_channel),
        .i_row             (i_row),
        .i_col             (i_col),
        .i_kernel_row      (i_kernel_row),
        .i_kernel_col      (i_kernel_col),
        .i_y_offset        (i_y_offset),
        .i_x_offset        (i_x_offset),
        .i_pixel_value     (i_pixel_value),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_sample_value    (o_sample_value),
        .i_sampled_channel (o_sampled_channel),
        .i_corner_row      (o_corner_row),
        .i_corner_col      (o_corner_col),
        .i_weight_top      (o_weight_top),
        .i_weight_left     (o_weight_left),
        .i_weight_bottom   (o_weight_bottom),
        .i_weight_right    (o_weight_right),
        .o_errors          (errors),
        .o_pending         (pending),
        .o_loads           (loads_seen),
        .o_samples         (samples_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (push && full) stalled_cycles++;
    end

    function automatic int usable(input logic [SIZE_W-1:0] v, input int hi);
        if (v < SIZE_MIN) return int'(SIZE_MIN);
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    function automatic int corner_of(input int pos, input int n);
        int c;
        if (pos < 0) pos = 0;
        if (pos > ((n - 1) << FRAC_BITS)) pos = (n - 1) << FRAC_BITS;
        c = pos >> FRAC_BITS;
        if (c >= n - 1) c = n - 2;
        return c;
    endfunction

    task automatic write_size(input logic sel, input logic [SIZE_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= {25'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_HEIGHT) rows_used = usable(value, MAX_HEIGHT);
        else cols_used = usable(value, MAX_WIDTH);
    endtask

    task automatic send_beat(
        input logic                    act,
        input logic [CH_W-1:0]         ch,
        input logic [ROW_W-1:0]        row,
        input logic [COL_W-1:0]        col,
        input logic [KER_W-1:0]        kr,
        input logic [KER_W-1:0]        kc,
        input logic signed [OFF_W-1:0] yo,
        input logic signed [OFF_W-1:0] xo,
        input logic signed [PIX_W-1:0] pix
    );
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 50) == 0) burst_left = 30;
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_action <= act;
        i_channel <= ch;
        i_row <= row;
        i_col <= col;
        i_kernel_row <= kr;
        i_kernel_col <= kc;
        i_y_offset <= yo;
        i_x_offset <= xo;
        i_pixel_value <= pix;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_pixel(input logic [CH_W-1:0] ch, input logic [ROW_W-1:0] row,
                              input logic [COL_W-1:0] col, input logic signed [PIX_W-1:0] pix);
        send_beat(ACT_LOAD, ch, row, col, KER_W'($urandom), KER_W'($urandom),
                  OFF_W'($urandom), OFF_W'($urandom), pix);
        loaded[{ch, row, col}] = 1'b1;
    endtask

    // Every neighbor a sample touches is loaded first, so no sample ever
    // reads a pixel that was never written.
    task automatic sample_at(
        input logic [CH_W-1:0]         ch,
        input logic [ROW_W-1:0]        row,
        input logic [COL_W-1:0]        col,
        input logic [KER_W-1:0]        kr,
        input logic [KER_W-1:0]        kc,
        input logic signed [OFF_W-1:0] yo,
        input logic signed [OFF_W-1:0] xo
    );
        int ay, ax, dy, dx;
        ay = corner_of((int'(row) + int'(kr)) * (1 << FRAC_BITS) + int'(yo), rows_used);
        ax = corner_of((int'(col) + int'(kc)) * (1 << FRAC_BITS) + int'(xo), cols_used);
        for (dy = 0; dy < 2; dy++) begin
            for (dx = 0; dx < 2; dx++) begin
                if (!loaded[{ch, ROW_W'(ay + dy), COL_W'(ax + dx)}]) begin
                    load_pixel(ch, ROW_W'(ay + dy), COL_W'(ax + dx), PIX_W'($urandom));
                end
            end
        end
        send_beat(ACT_SAMPLE, ch, row, col, kr, kc, yo, xo, PIX_W'($urandom));
    endtask

    task automatic random_sample();
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic [KER_W-1:0]        kr;
        logic [KER_W-1:0]        kc;
        logic signed [OFF_W-1:0] yo;
        logic signed [OFF_W-1:0] xo;
        int                      ty, tx;
        if ($urandom_range(0, 4) == 0) begin
            row = ROW_W'($urandom);
            col = COL_W'($urandom);
            kr = KER_W'($urandom);
            kc = KER_W'($urandom);
            yo = OFF_W'($urandom);
            xo = OFF_W'($urandom);
        end else begin
            ty = $urandom_range(0, rows_used - 1);
            tx = $urandom_range(0, cols_used - 1);
            kr = KER_W'($urandom_range(0, (ty < 15) ? ty : 15));
            kc = KER_W'($urandom_range(0, (tx < 15) ? tx : 15));
            row = ROW_W'(ty - int'(kr));
            col = COL_W'(tx - int'(kc));
            yo = OFF_W'(int'($urandom_range(0, 767)) - 384);
            xo = OFF_W'(int'($urandom_range(0, 767)) - 384);
        end
        sample_at(CH_W'($urandom), row, col, kr, kc, yo, xo);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int popped, hold, quiet_left;
        pop = 1'b0;
        popped = 0;
        quiet_left = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (popped == LONG_HOLD_AT) begin
                hold = LONG_HOLD;
            end else if (quiet_left > 0) begin
                hold = 0;
                quiet_left--;
            end else begin
                hold = $urandom_range(0, 13);
                if ($urandom_range(0, 40) == 0) quiet_left = 40;
            end
            if (hold > 0) begin
                pop <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            popped++;
            @(negedge i_clk);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (psel && penable && pwrite && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("deformable_im2col_bilinear_sampler_top: mismatch");
        $finish;
    end

    initial begin
        int phase, goal;
        logic [SIZE_W-1:0] h_val, w_val;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        i_action = ACT_LOAD;
        i_channel = '0;
        i_row = '0;
        i_col = '0;
        i_kernel_row = '0;
        i_kernel_col = '0;
        i_y_offset = '0;
        i_x_offset = '0;
        i_pixel_value = '0;
        stalled_cycles = 0;
        beats_sent = 0;
        burst_left = 0;
        rows_used = MAX_HEIGHT;
        cols_used = MAX_WIDTH;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) drain();
            h_val = (phase < 8) ? phase_h[phase] : SIZE_W'($urandom_range(2, 64));
            w_val = (phase < 8) ? phase_w[phase] : SIZE_W'($urandom_range(2, 64));
            write_size(REG_HEIGHT, h_val);
            write_size(REG_WIDTH, w_val);
            if (phase == 0) begin
                load_pixel(3, 0, 0, 16'sh7fff);
                load_pixel(3, 0, 1, 16'sh8000);
                load_pixel(3, 1, 0, -16'sd1);
                load_pixel(3, 1, 1, 16'sd0);
                sample_at(3, 0, 0, 0, 0, 15'sd128, 15'sd128);
                sample_at(3, 0, 0, 0, 0, 15'sh4000, 15'sh4000);
                sample_at(3, 1, 0, 0, 0, 15'sd0, 15'sd128);
                load_pixel(0, 62, 62, 16'sh8000);
                load_pixel(0, 62, 63, 16'sh7fff);
                load_pixel(0, 63, 62, 16'sh7fff);
                load_pixel(0, 63, 63, 16'sh8000);
                sample_at(0, 63, 63, 15, 15, 15'sh3fff, 15'sh3fff);
                sample_at(0, 63, 63, 0, 0, 15'sd0, 15'sd0);
                sample_at(0, 62, 62, 0, 0, 15'sd255, 15'sd255);
                sample_at(0, 48, 48, 15, 15, -15'sd1, -15'sd1);
            end
            goal = beats_sent + BEATS_PER_PHASE;
            while (beats_sent < goal) begin
                if ($urandom_range(0, 99) < 15)
                    load_pixel(CH_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
                               PIX_W'($urandom));
                else
                    random_sample();
            end
        end
        drain();

        $display("Covered %0d pixel loads and %0d samples over %0d image size settings.",
                 loads_seen, samples_seen, PHASES);
        $display("Input was held off by a full block for %0d cycles in total.", stalled_cycles);
        if (errors == 0 && pending == 0)
            $display("deformable_im2col_bilinear_sampler_top: match");
        else
            $display("deformable_im2col_bilinear_sampler_top: mismatch");
        $finish;
    end

endmodule

[deformable_im2col_bilinear_sampler_top.f]
rtl/dibs_pkg.sv
rtl/dibs_front.sv
rtl/dibs_back.sv
rtl/deformable_im2col_bilinear_sampler_top.sv
tb/sv/dibs_sample_checker.sv
tb/sv/tb.sv
